/* sv/csl_pkg.sv */
package csl_pkg;

  // Default coordinate width of the position and goal registers.
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // Host and result fields are fixed at 16 bits.
  localparam int unsigned FIELD_W = 16;

  // Configuration port geometry.
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 2;

  // Register indexes (byte address divided by four).
  localparam logic [REG_IDX_W-1:0] REG_DIV_X   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIV_Y   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_X = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_Y = 2'd3;

  // Register widths and reset values.
  localparam int unsigned DIV_W   = 8;
  localparam int unsigned LIMIT_W = 16;
  localparam logic [DIV_W-1:0]   DIV_RST   = 8'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'hFFFF;

  // The shared divider retires one quotient bit per cycle.
  localparam int unsigned DIV_STEPS = FIELD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Command codes.
  localparam logic CMD_SET_TARGET = 1'b0;
  localparam logic CMD_TICK       = 1'b1;

  // Axis select for the shared divider and goal write.
  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef struct packed {
    logic                      command;
    logic signed [FIELD_W-1:0] host_x;
    logic signed [FIELD_W-1:0] host_y;
  } csl_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] position_x;
    logic signed [FIELD_W-1:0] position_y;
  } csl_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;     // capture the input item
    logic div_init;  // load the divider with one axis
    logic div_sel;   // axis loaded by div_init
    logic div_step;  // retire one quotient bit
    logic goal_wr;   // store the finished quotient as a goal
    logic goal_sel;  // axis written by goal_wr
    logic pos_upd;   // apply snap or tick to both axes
  } csl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;  // the current step is the divider's last
  } csl_sts_t;

endpackage

/* sv/csl_axis.sv */
// Per-axis position update: snap check for a new goal, or one bounded tick.
module csl_axis #(
  parameter int unsigned COORD_WIDTH = csl_pkg::COORD_WIDTH_DEF
) (
  input  logic [COORD_WIDTH-1:0]           cur_i,
  input  logic [COORD_WIDTH-1:0]           goal_i,
  input  logic [csl_pkg::LIMIT_W-1:0]      limit_i,
  input  logic                             tick_i,
  output logic [COORD_WIDTH-1:0]           nxt_o
);

  localparam int unsigned SW = COORD_WIDTH + 1;
  localparam int unsigned DW = (SW > csl_pkg::LIMIT_W) ? SW : csl_pkg::LIMIT_W;

  logic [SW-1:0] diff;
  logic [SW-1:0] mag;
  logic [DW-1:0] mag_e;
  logic [DW-1:0] lim_e;
  logic [DW-1:0] step;
  logic          snap;

  // Signed distance to the goal and its magnitude.
  assign diff  = {goal_i[COORD_WIDTH-1], goal_i} - {cur_i[COORD_WIDTH-1], cur_i};
  assign mag   = diff[SW-1] ? (~diff + SW'(1)) : diff;
  assign mag_e = DW'(mag);
  assign lim_e = DW'(limit_i);

  // Snap when a new goal is too far away; ticks move by the smaller amount.
  assign snap = (mag_e >> 3) > lim_e;
  assign step = (mag_e < lim_e) ? mag_e : lim_e;

  always_comb begin
    nxt_o = cur_i;
    if (tick_i) begin
      if (diff[SW-1]) begin
        nxt_o = cur_i - step[COORD_WIDTH-1:0];
      end else if (diff != '0) begin
        nxt_o = cur_i + step[COORD_WIDTH-1:0];
      end
    end else if (snap) begin
      nxt_o = goal_i;
    end
  end

endmodule

/* sv/csl_dp.sv */
// Datapath: input capture, shared restoring divider, goal and position registers.
module csl_dp #(
  parameter int unsigned COORD_WIDTH = csl_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  csl_pkg::csl_in_t              in_data_i,
  input  logic [csl_pkg::DIV_W-1:0]     div_x_i,
  input  logic [csl_pkg::DIV_W-1:0]     div_y_i,
  input  logic [csl_pkg::LIMIT_W-1:0]   limit_x_i,
  input  logic [csl_pkg::LIMIT_W-1:0]   limit_y_i,
  input  csl_pkg::csl_cmd_t             cmd_i,
  output csl_pkg::csl_sts_t             sts_o,
  output logic [COORD_WIDTH-1:0]        cur_x_o,
  output logic [COORD_WIDTH-1:0]        cur_y_o
);

  localparam int unsigned FW = csl_pkg::FIELD_W;
  localparam int unsigned DV = csl_pkg::DIV_W;
  localparam int unsigned XW = 2 * csl_pkg::APB_DATA_W + 1;

  logic                             tick_q;
  logic [FW-1:0]                    host_x_q, host_y_q;
  logic [DV-1:0]                    dsr_q, dsr_d;
  logic [DV-1:0]                    rem_q, rem_d;
  logic [FW-1:0]                    quo_q, quo_d;
  logic                             neg_q, neg_d;
  logic [csl_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [COORD_WIDTH-1:0]           goal_x_q, goal_y_q;
  logic [COORD_WIDTH-1:0]           cur_x_q, cur_y_q;
  logic [COORD_WIDTH-1:0]           nxt_x, nxt_y;

  logic [FW-1:0]                    host_sel;
  logic [DV-1:0]                    div_sel;
  logic [DV:0]                      trial;
  logic [DV:0]                      diff;
  logic [FW:0]                      q_signed;
  logic [XW-1:0]                    q_ext;
  logic [COORD_WIDTH-1:0]           goal_val;

  // Capture the item at acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      tick_q   <= in_data_i.command;
      host_x_q <= in_data_i.host_x;
      host_y_q <= in_data_i.host_y;
    end
  end

  // Operand selection for the divider; a zero divider acts as one.
  // On the capture cycle the X operand comes straight from the input item.
  assign host_sel = cmd_i.latch ? in_data_i.host_x
                  : (cmd_i.div_sel == csl_pkg::AXIS_X) ? host_x_q : host_y_q;
  assign div_sel  = (cmd_i.div_sel == csl_pkg::AXIS_X) ? div_x_i : div_y_i;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem_q, quo_q[FW-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    dsr_d = dsr_q;
    rem_d = rem_q;
    quo_d = quo_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    if (cmd_i.div_init) begin
      dsr_d = (div_sel == '0) ? DV'(1) : div_sel;
      rem_d = '0;
      quo_d = host_sel[FW-1] ? (~host_sel + FW'(1)) : host_sel;
      neg_d = host_sel[FW-1];
      cnt_d = '0;
    end else if (cmd_i.div_step) begin
      if (!diff[DV]) begin
        rem_d = diff[DV-1:0];
        quo_d = {quo_q[FW-2:0], 1'b1};
      end else begin
        rem_d = trial[DV-1:0];
        quo_d = {quo_q[FW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
  end

  assign sts_o.div_last = (cnt_q == csl_pkg::DIV_CNT_W'(csl_pkg::DIV_STEPS - 1));

  // Apply the sign, then wrap the quotient to the coordinate width.
  assign q_signed = neg_q ? (~{1'b0, quo_q} + (FW+1)'(1)) : {1'b0, quo_q};
  assign q_ext    = {{(XW-FW-1){q_signed[FW]}}, q_signed};
  assign goal_val = q_ext[COORD_WIDTH-1:0];

  // Per-axis snap or tick.
  csl_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_x (
    .cur_i   (cur_x_q),
    .goal_i  (goal_x_q),
    .limit_i (limit_x_i),
    .tick_i  (tick_q),
    .nxt_o   (nxt_x)
  );

  csl_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_y (
    .cur_i   (cur_y_q),
    .goal_i  (goal_y_q),
    .limit_i (limit_y_i),
    .tick_i  (tick_q),
    .nxt_o   (nxt_y)
  );

  // Goal and position state, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q <= '0;
      goal_y_q <= '0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
    end else begin
      if (cmd_i.goal_wr && (cmd_i.goal_sel == csl_pkg::AXIS_X)) begin
        goal_x_q <= goal_val;
      end
      if (cmd_i.goal_wr && (cmd_i.goal_sel == csl_pkg::AXIS_Y)) begin
        goal_y_q <= goal_val;
      end
      if (cmd_i.pos_upd) begin
        cur_x_q <= nxt_x;
        cur_y_q <= nxt_y;
      end
    end
  end

  assign cur_x_o = cur_x_q;
  assign cur_y_o = cur_y_q;

endmodule

/* sv/csl_ctrl.sv */
// Controller: sequences one item through divide and goal write (set-target only), update and output.
module csl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_command_i,
  output logic               in_ready_o,
  input  logic               out_free_i,
  output logic               out_load_o,
  input  csl_pkg::csl_sts_t  sts_i,
  output csl_pkg::csl_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV_X  = 3'd1;
  localparam logic [2:0] ST_GOAL_X = 3'd2;
  localparam logic [2:0] ST_DIV_Y  = 3'd3;
  localparam logic [2:0] ST_GOAL_Y = 3'd4;
  localparam logic [2:0] ST_UPDATE = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.div_sel  = csl_pkg::AXIS_X;
        if (in_valid_i) begin
          // The X divide is loaded in the same cycle the item is captured.
          cmd_o.latch    = 1'b1;
          cmd_o.div_init = 1'b1;
          state_d = (in_command_i == csl_pkg::CMD_TICK) ? ST_UPDATE : ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_GOAL_X;
        end
      end
      ST_GOAL_X: begin
        cmd_o.goal_wr  = 1'b1;
        cmd_o.goal_sel = csl_pkg::AXIS_X;
        cmd_o.div_init = 1'b1;
        cmd_o.div_sel  = csl_pkg::AXIS_Y;
        state_d = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_GOAL_Y;
        end
      end
      ST_GOAL_Y: begin
        cmd_o.goal_wr  = 1'b1;
        cmd_o.goal_sel = csl_pkg::AXIS_Y;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.pos_upd = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/coordinate_slew_limiter_unit.sv */
// Channel   Signals                          Direction  Transfer when
// in        in_valid_i/in_ready_o/in_data_i   in         in_valid_i && in_ready_o
// out       out_valid_o/out_ready_i/out_data_o out       out_valid_o && out_ready_i
// config    psel/penable/pwrite/paddr/...     in         psel && penable && pwrite
//
// A set-target item runs two passes of the shared one-bit-per-cycle divider,
// two goal writes, the update and the output load; a tick item runs only the
// update and the output load. One item is in work at a time; the next is taken
// from the cycle after the load, while the previous result may still wait in
// the output register. A full output register stalls only the final load.
// Reset initializes control, config, goal, position and output valid only.
module coordinate_slew_limiter_unit #(
  parameter int unsigned COORD_WIDTH = csl_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  csl_pkg::csl_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output csl_pkg::csl_out_t                 out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [csl_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [csl_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [csl_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int unsigned FW = csl_pkg::FIELD_W;
  localparam int unsigned XW = 2 * csl_pkg::APB_DATA_W;

  logic [csl_pkg::DIV_W-1:0]    div_x_q, div_y_q;
  logic [csl_pkg::LIMIT_W-1:0]  limit_x_q, limit_y_q;
  logic [csl_pkg::REG_IDX_W-1:0] reg_idx;
  logic                         cfg_wr;

  csl_pkg::csl_cmd_t            cmd;
  csl_pkg::csl_sts_t            sts;
  logic                         out_load;
  logic                         out_valid_q;
  csl_pkg::csl_out_t            out_data_q;
  logic [COORD_WIDTH-1:0]       cur_x, cur_y;
  logic [XW-1:0]                cur_x_ext, cur_y_ext;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[csl_pkg::APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_x_q   <= csl_pkg::DIV_RST;
      div_y_q   <= csl_pkg::DIV_RST;
      limit_x_q <= csl_pkg::LIMIT_RST;
      limit_y_q <= csl_pkg::LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        csl_pkg::REG_DIV_X:   div_x_q   <= pwdata[csl_pkg::DIV_W-1:0];
        csl_pkg::REG_DIV_Y:   div_y_q   <= pwdata[csl_pkg::DIV_W-1:0];
        csl_pkg::REG_LIMIT_X: limit_x_q <= pwdata[csl_pkg::LIMIT_W-1:0];
        csl_pkg::REG_LIMIT_Y: limit_y_q <= pwdata[csl_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      csl_pkg::REG_DIV_X:   prdata = csl_pkg::APB_DATA_W'(div_x_q);
      csl_pkg::REG_DIV_Y:   prdata = csl_pkg::APB_DATA_W'(div_y_q);
      csl_pkg::REG_LIMIT_X: prdata = csl_pkg::APB_DATA_W'(limit_x_q);
      csl_pkg::REG_LIMIT_Y: prdata = csl_pkg::APB_DATA_W'(limit_y_q);
      default:              prdata = '0;
    endcase
  end

  csl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_ready_o   (in_ready_o),
    .out_free_i   (!out_valid_q || out_ready_i),
    .out_load_o   (out_load),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  csl_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .div_x_i   (div_x_q),
    .div_y_i   (div_y_q),
    .limit_x_i (limit_x_q),
    .limit_y_i (limit_y_q),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .cur_x_o   (cur_x),
    .cur_y_o   (cur_y)
  );

  // Output register; the result carries the low 16 bits of each position.
  assign cur_x_ext = {{(XW-COORD_WIDTH){cur_x[COORD_WIDTH-1]}}, cur_x};
  assign cur_y_ext = {{(XW-COORD_WIDTH){cur_y[COORD_WIDTH-1]}}, cur_y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.position_x <= cur_x_ext[FW-1:0];
      out_data_q.position_y <= cur_y_ext[FW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
